>>> rtl/core/quadrature_decoder_with_velocity_macros.svh
`ifndef QUADRATURE_DECODER_WITH_VELOCITY_MACROS_SVH
`define QUADRATURE_DECODER_WITH_VELOCITY_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define QDV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define QDV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/qdv_pkg.sv
package qdv_pkg;

  localparam int POS_W     = 32;
  localparam int FRAC_W    = 8;
  localparam int CPR_W     = 34;
  localparam int WIN_W     = 16;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 1;

  localparam longint unsigned SPEED_K = 64'd60000 << FRAC_W;
  localparam int K_W    = $clog2(SPEED_K + 1);
  localparam int PROD_W = POS_W + K_W;
  localparam int DIV_W  = CPR_W + WIN_W;
  localparam int CNT_W  = $clog2(PROD_W);

  localparam logic [CFG_IDX_W-1:0] REG_CPR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WIN = CFG_IDX_W'(1);

  localparam logic [CPR_W-1:0] CPR_RESET = CPR_W'(4096);
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(100);

  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

>>> rtl/core/quadrature_decoder_with_velocity.sv
// X4 quadrature decoder with windowed speed measurement. Each input transfer
// carries one sample of the A and B levels plus a millisecond tick and a clear
// flag, and yields exactly one output transfer with the position, the latest
// speed in rpm (signed, 8 fraction bits) and two flags. A sample that does not
// close a speed window is answered in the next cycle. A sample whose tick
// closes a window holds off the next input until its speed is presented: it is
// accepted, the two multipliers form the scaled dividend and the divisor, the
// restoring divider resolves one quotient bit per cycle, and the final state
// saturates and presents the speed once the output is free. The configuration
// registers must only be written while the block is idle.
`include "quadrature_decoder_with_velocity_macros.svh"

module quadrature_decoder_with_velocity (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [qdv_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [qdv_pkg::CPR_W-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             pin_a_i,
  input  logic                             pin_b_i,
  input  logic                             ms_tick_i,
  input  logic                             clear_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [qdv_pkg::OUT_W-1:0] position_o,
  output logic signed [qdv_pkg::OUT_W-1:0] speed_rpm_o,
  output logic                             speed_updated_o,
  output logic                             step_error_o
);
  import qdv_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CPR_W-1:0] cpr_q;
  logic [WIN_W-1:0] win_q;

  logic             prev_a_q, prev_b_q, primed_q;
  logic [POS_W-1:0] count_q, start_q, delta_q;
  logic [WIN_W-1:0] timer_q;
  logic [OUT_W-1:0] speed_q;
  logic             err_q;

  logic [PROD_W-1:0] prod_q;
  logic [DIV_W-1:0]  div_q;
  logic [DIV_W-1:0]  rem_q;
  logic [OUT_W-1:0]  quo_q;
  logic              ovf_q;
  logic              neg_q;
  logic [CNT_W-1:0]  cnt_q;

  logic              out_valid_q;
  logic [OUT_W-1:0]  pos_out_q, spd_out_q;
  logic              upd_out_q, err_out_q;

  logic             in_fire, out_free, ca, cb, step_err, close;
  logic [POS_W-1:0] count_dec, mag;
  logic [WIN_W:0]   timer_inc;
  logic [WIN_W-1:0] win_eff;
  logic [DIV_W:0]   rem_sh;
  logic             rem_ge;
  logic             big;
  logic [OUT_W-1:0] speed_res;
  logic             fin_write;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign fin_write  = (state_q == ST_FIN) && out_free;

  assign win_eff = (win_q == '0) ? WIN_W'(1) : win_q;

  always_comb begin
    ca        = pin_a_i ^ prev_a_q;
    cb        = pin_b_i ^ prev_b_q;
    step_err  = primed_q && ca && cb;
    count_dec = count_q;
    if (primed_q && !step_err) begin
      if (ca) begin
        count_dec = (pin_a_i != prev_b_q) ? count_q + POS_W'(1) : count_q - POS_W'(1);
      end else if (cb) begin
        count_dec = (prev_a_q == pin_b_i) ? count_q + POS_W'(1) : count_q - POS_W'(1);
      end
    end
    timer_inc = {1'b0, timer_q} + (WIN_W+1)'(1);
    close     = !clear_i && ms_tick_i && (timer_inc >= {1'b0, win_eff});
  end

  assign mag    = delta_q[POS_W-1] ? (~delta_q + POS_W'(1)) : delta_q;
  assign rem_sh = {rem_q, prod_q[PROD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_q};

  always_comb begin
    big = ovf_q || quo_q[OUT_W-1];
    if (delta_q == '0) begin
      speed_res = '0;
    end else if (neg_q) begin
      speed_res = big ? SAT_NEG : (~quo_q + OUT_W'(1));
    end else begin
      speed_res = big ? SAT_POS : quo_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && close) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cpr_q       <= CPR_RESET;
      win_q       <= WIN_RESET;
      prev_a_q    <= 1'b0;
      prev_b_q    <= 1'b0;
      primed_q    <= 1'b0;
      count_q     <= '0;
      start_q     <= '0;
      timer_q     <= '0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CPR: cpr_q <= cfg_wdata_i;
          REG_WIN: win_q <= cfg_wdata_i[WIN_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        prev_a_q <= pin_a_i;
        prev_b_q <= pin_b_i;
        primed_q <= 1'b1;
        if (clear_i) begin
          count_q <= '0;
          start_q <= '0;
          timer_q <= '0;
          speed_q <= '0;
        end else begin
          count_q <= count_dec;
          if (close) begin
            start_q <= count_dec;
            timer_q <= '0;
          end else if (ms_tick_i) begin
            timer_q <= timer_inc[WIN_W-1:0];
          end
        end
      end
      if (fin_write) begin
        speed_q <= speed_res;
      end
      if ((in_fire && !close) || fin_write) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      delta_q <= count_dec - start_q;
      err_q   <= step_err;
      if (!close) begin
        pos_out_q <= clear_i ? '0 : OUT_W'(signed'(count_dec));
        spd_out_q <= clear_i ? '0 : speed_q;
        upd_out_q <= 1'b0;
        err_out_q <= step_err;
      end
    end
    if (state_q == ST_MUL) begin
      neg_q  <= delta_q[POS_W-1];
      prod_q <= PROD_W'(mag) * PROD_W'(SPEED_K);
      div_q  <= DIV_W'(cpr_q) * DIV_W'(win_eff);
      rem_q  <= '0;
      quo_q  <= '0;
      ovf_q  <= 1'b0;
      cnt_q  <= CNT_W'(PROD_W - 1);
    end
    if (state_q == ST_DIV) begin
      prod_q <= {prod_q[PROD_W-2:0], 1'b0};
      rem_q  <= rem_ge ? DIV_W'(rem_sh - {1'b0, div_q}) : rem_sh[DIV_W-1:0];
      quo_q  <= {quo_q[OUT_W-2:0], rem_ge};
      ovf_q  <= ovf_q || quo_q[OUT_W-1];
      cnt_q  <= cnt_q - CNT_W'(1);
    end
    if (fin_write) begin
      pos_out_q <= OUT_W'(signed'(count_q));
      spd_out_q <= speed_res;
      upd_out_q <= 1'b1;
      err_out_q <= err_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign position_o      = signed'(pos_out_q);
  assign speed_rpm_o     = signed'(spd_out_q);
  assign speed_updated_o = upd_out_q;
  assign step_error_o    = err_out_q;

  `QDV_ASSERT_NOW(a_busy_not_ready, state_q != ST_IDLE, !in_ready_o, "ready while busy")
  `QDV_ASSERT_NEXT(a_close_starts_mul, in_fire && close, state_q == ST_MUL, "window close lost")
  `QDV_ASSERT_NEXT(a_div_ends, state_q == ST_DIV && cnt_q == '0, state_q == ST_FIN,
                   "divider overran")
  `QDV_ASSERT_NEXT(a_clear_zeroes, in_fire && clear_i,
                   out_valid_o && position_o == '0 && speed_rpm_o == '0 && !speed_updated_o,
                   "clear did not zero the result")

endmodule
